// ===== hdl/stc_pkg.sv =====
// ----------------------------------------------------------------------------
// stc_pkg: shared constants and helpers
// Field widths, pipeline depth, input range limits and the month offset table.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int unsigned InW    = 39;
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned YdayW  = 9;
  localparam int unsigned WeekW  = 6;

  // Register stages from the input beat to the output register.
  localparam int unsigned NumStages = 23;

  // Valid input window: 0001-01-01 00:00:00 .. 9999-12-31 23:59:59
  localparam logic signed [InW-1:0] MinSeconds = -39'sd60052752000;
  localparam logic signed [InW-1:0] MaxSeconds = 39'sd255485145599;

  // Day offset of a March-based month index, (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    unique case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/stc_if.sv =====
// ----------------------------------------------------------------------------
// stc_if: channel interfaces
// Valid/ready channels for the seconds input and the calendar result.
// ----------------------------------------------------------------------------
interface stc_in_if
  import stc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic signed [InW-1:0] seconds_since_1904;

  modport source (output valid, output seconds_since_1904, input ready);
  modport sink   (input valid, input seconds_since_1904, output ready);
endinterface

interface stc_out_if
  import stc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [DayW-1:0]   day;
  logic [HourW-1:0]  hour;
  logic [MinW-1:0]   minute;
  logic [SecW-1:0]   second;
  logic [WdayW-1:0]  weekday;
  logic [YdayW-1:0]  day_of_year;
  logic [WeekW-1:0]  week_of_year;
  logic              afternoon;
  logic              out_of_range;

  modport source (
    output valid, output year, output month, output day, output hour,
    output minute, output second, output weekday, output day_of_year,
    output week_of_year, output afternoon, output out_of_range,
    input  ready
  );
  modport sink (
    input  valid, input year, input month, input day, input hour,
    input  minute, input second, input weekday, input day_of_year,
    input  week_of_year, input afternoon, input out_of_range,
    output ready
  );
endinterface

// ===== hdl/seconds_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// seconds_to_calendar_date: seconds since 1904 to Gregorian calendar fields
// Pipeline: seven chained constant dividers of two stages each, plus glue
//   stages between them, lead from the input beat to the output beat.
// Throughput: one beat per cycle; each stage holds under backpressure and
//   empty stages fill behind a stalled one.
// Reset: clears only the valid bits of the pipeline; data registers hold.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date
  import stc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  stc_in_if.sink    in_i,
  stc_out_if.source out_o
);

  // Working set carried down the pipe; each stage copies its predecessor
  // and fills in what it computes. Unused bits fall away in synthesis.
  typedef struct packed {
    logic             oor;     // outside years 1..9999
    logic [6:0]       lo7;     // low bits of seconds from year 1
    logic [31:0]      x7;      // seconds from year 1, divided by 128
    logic [16:0]      sod;     // second of day
    logic [21:0]      z;       // days from 0000-03-01
    logic [21:0]      w;       // day index + 1, for weekday
    logic [SecW-1:0]  sec;
    logic [10:0]      m60;     // minute of day
    logic [4:0]       era;     // 400-year cycle
    logic [17:0]      doe;     // day of cycle
    logic [WdayW-1:0] wday;    // 0 is Sunday
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [17:0]      n;       // leap-corrected day of cycle
    logic [8:0]       yoe;     // year of cycle
    logic [6:0]       r100;    // yoe mod 100
    logic [2:0]       q100;    // yoe / 100
    logic             leap;
    logic [8:0]       doy;     // March-based day of year
    logic [YearW-1:0] y;       // March-based year
    logic [10:0]      a;       // 5 * doy + 2
    logic [MonthW-1:0] month;
    logic [DayW-1:0]  day;
    logic [YdayW-1:0] yday;    // zero-based
    logic [8:0]       wk;      // yday + 7 - wday
  } stage_t;

  localparam int unsigned NI = NumStages - 1;  // stages ahead of output reg

  logic [NumStages-1:0] en;
  logic                 out_valid;
  stage_t               s_q [NI];
  stage_t               s_d [NI];

  // Divider results
  logic [22:0] q675;  logic [9:0]  r675;
  logic [11:0] q60;   logic [5:0]  r60;
  logic [4:0]  qera;  logic [17:0] rera;
  logic [2:0]  r7;
  logic [5:0]  q60b;  logic [5:0]  r60b;
  logic [7:0]  q1460;
  logic [2:0]  q36524;
  logic [9:0]  q365;
  logic [2:0]  qy100; logic [6:0]  ry100;
  logic [3:0]  q153;
  logic [6:0]  qwk;

  stc_flow #(.NS(NumStages)) u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_valid),
    .en_o        (en)
  );

  // Seconds / 86400 as (seconds >> 7) / 675
  stc_cdiv #(.XW(32), .D(675), .QW(23), .RW(10)) u_div_day (
    .clk_i (clk_i), .en_a_i (en[1]), .en_b_i (en[2]),
    .x_i (s_q[0].x7), .q_o (q675), .r_o (r675)
  );

  // Minute of day and second
  stc_cdiv #(.XW(17), .D(60), .QW(12), .RW(6)) u_div_sec (
    .clk_i (clk_i), .en_a_i (en[4]), .en_b_i (en[5]),
    .x_i (s_q[3].sod), .q_o (q60), .r_o (r60)
  );

  // 400-year era and day of era
  stc_cdiv #(.XW(22), .D(146097), .QW(5), .RW(18)) u_div_era (
    .clk_i (clk_i), .en_a_i (en[4]), .en_b_i (en[5]),
    .x_i (s_q[3].z), .q_o (qera), .r_o (rera)
  );

  // Weekday; day 0 of the count (year 1) was a Monday
  stc_cdiv #(.XW(22), .D(7), .QW(20), .RW(3)) u_div_wday (
    .clk_i (clk_i), .en_a_i (en[4]), .en_b_i (en[5]),
    .x_i (s_q[3].w), .q_o (), .r_o (r7)
  );

  // Hour and minute
  stc_cdiv #(.XW(11), .D(60), .QW(6), .RW(6)) u_div_min (
    .clk_i (clk_i), .en_a_i (en[7]), .en_b_i (en[8]),
    .x_i (s_q[6].m60), .q_o (q60b), .r_o (r60b)
  );

  // Leap-day corrections within the era
  stc_cdiv #(.XW(18), .D(1460), .QW(8), .RW(11)) u_div_4y (
    .clk_i (clk_i), .en_a_i (en[7]), .en_b_i (en[8]),
    .x_i (s_q[6].doe), .q_o (q1460), .r_o ()
  );

  stc_cdiv #(.XW(18), .D(36524), .QW(3), .RW(16)) u_div_100y (
    .clk_i (clk_i), .en_a_i (en[7]), .en_b_i (en[8]),
    .x_i (s_q[6].doe), .q_o (q36524), .r_o ()
  );

  // Year of era
  stc_cdiv #(.XW(18), .D(365), .QW(10), .RW(9)) u_div_yoe (
    .clk_i (clk_i), .en_a_i (en[10]), .en_b_i (en[11]),
    .x_i (s_q[9].n), .q_o (q365), .r_o ()
  );

  // Century within the era
  stc_cdiv #(.XW(9), .D(100), .QW(3), .RW(7)) u_div_cent (
    .clk_i (clk_i), .en_a_i (en[13]), .en_b_i (en[14]),
    .x_i (s_q[12].yoe), .q_o (qy100), .r_o (ry100)
  );

  // March-based month index
  stc_cdiv #(.XW(11), .D(153), .QW(4), .RW(8)) u_div_mon (
    .clk_i (clk_i), .en_a_i (en[17]), .en_b_i (en[18]),
    .x_i (s_q[16].a), .q_o (q153), .r_o ()
  );

  // Sunday-started week number
  stc_cdiv #(.XW(9), .D(7), .QW(7), .RW(3)) u_div_week (
    .clk_i (clk_i), .en_a_i (en[20]), .en_b_i (en[21]),
    .x_i (s_q[19].wk), .q_o (qwk), .r_o ()
  );

  logic [InW-1:0] t;
  logic [8:0]     mstart;

  always_comb begin
    for (int k = 1; k < NI; k++) begin
      s_d[k] = s_q[k-1];
    end

    // Stage 0: range check, rebase to 0001-01-01. Out of range leaves
    // garbage in the data path; the output stage masks it.
    t        = in_i.seconds_since_1904 - MinSeconds;
    s_d[0]   = '0;
    s_d[0].oor = (in_i.seconds_since_1904 < MinSeconds) ||
                 (in_i.seconds_since_1904 > MaxSeconds);
    s_d[0].lo7 = t[6:0];
    s_d[0].x7  = t[InW-1:7];

    // Stage 3: day index and second of day
    s_d[3].sod = {r675, s_q[2].lo7};
    s_d[3].z   = q675[21:0] + 22'd306;
    s_d[3].w   = q675[21:0] + 22'd1;

    // Stage 6
    s_d[6].sec  = r60;
    s_d[6].m60  = q60[10:0];
    s_d[6].era  = qera;
    s_d[6].doe  = rera;
    s_d[6].wday = r7;

    // Stage 9: the last day of an era counts as a 4th-century leap day
    s_d[9].hour   = q60b[HourW-1:0];
    s_d[9].minute = r60b;
    s_d[9].n      = s_q[8].doe - 18'(q1460) + 18'(q36524)
                    - 18'(s_q[8].doe == 18'd146096);

    // Stage 12
    s_d[12].yoe = q365[8:0];

    // Stage 15: day of year and year; yoe equals year mod 400
    s_d[15].q100 = qy100;
    s_d[15].r100 = ry100;
    s_d[15].leap = ((s_q[14].yoe[1:0] == 2'd0) && (ry100 != 7'd0)) ||
                   (s_q[14].yoe == 9'd0);
    s_d[15].doy  = 9'(s_q[14].doe - 18'(s_q[14].yoe) * 18'd365
                      - 18'(s_q[14].yoe >> 2) + 18'(qy100));
    s_d[15].y    = YearW'(s_q[14].yoe) + YearW'(s_q[14].era) * YearW'(400);

    // Stage 16
    s_d[16].a = 11'(s_q[15].doy) * 11'd5 + 11'd2;

    // Stage 19: month, day, January-based day of year
    mstart        = month_start(q153);
    s_d[19].day   = DayW'(s_q[18].doy - mstart + 9'd1);
    s_d[19].month = (q153 < 4'd10) ? q153 + 4'd3 : q153 - 4'd9;
    s_d[19].y     = s_q[18].y + YearW'(s_d[19].month <= 4'd2);
    s_d[19].yday  = (s_d[19].month >= 4'd3) ?
                    YdayW'(s_q[18].doy + 9'd59 + 9'(s_q[18].leap)) :
                    YdayW'(s_q[18].doy - 9'd306);
    s_d[19].wk    = s_d[19].yday + 9'd7 - 9'(s_q[18].wday);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NI; k++) begin
      if (en[k]) begin
        s_q[k] <= s_d[k];
      end
    end
  end

  // Output register; an out-of-range beat carries only its flag.
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
    logic [WdayW-1:0]  weekday;
    logic [YdayW-1:0]  day_of_year;
    logic [WeekW-1:0]  week_of_year;
    logic              afternoon;
    logic              out_of_range;
  } result_t;

  result_t res_d, res_q;
  stage_t  last;

  always_comb begin
    last  = s_q[NI-1];
    res_d = '0;
    if (last.oor) begin
      res_d.out_of_range = 1'b1;
    end else begin
      res_d.year         = last.y;
      res_d.month        = last.month;
      res_d.day          = last.day;
      res_d.hour         = last.hour;
      res_d.minute       = last.minute;
      res_d.second       = last.sec;
      res_d.weekday      = last.wday + WdayW'(1);
      res_d.day_of_year  = last.yday + YdayW'(1);
      res_d.week_of_year = WeekW'(qwk) + WeekW'(1);
      res_d.afternoon    = (last.hour >= HourW'(12));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid;
  assign out_o.year         = res_q.year;
  assign out_o.month        = res_q.month;
  assign out_o.day          = res_q.day;
  assign out_o.hour         = res_q.hour;
  assign out_o.minute       = res_q.minute;
  assign out_o.second       = res_q.second;
  assign out_o.weekday      = res_q.weekday;
  assign out_o.day_of_year  = res_q.day_of_year;
  assign out_o.week_of_year = res_q.week_of_year;
  assign out_o.afternoon    = res_q.afternoon;
  assign out_o.out_of_range = res_q.out_of_range;

endmodule

// ===== hdl/stc_cdiv.sv =====
// ----------------------------------------------------------------------------
// stc_cdiv: two-stage divider by a constant
// Reciprocal multiply gives a quotient low by at most one; the second
// stage fixes it with one compare and subtract.
// ----------------------------------------------------------------------------
module stc_cdiv #(
  parameter int unsigned XW = 32,
  parameter int unsigned D  = 675,
  parameter int unsigned QW = 23,
  parameter int unsigned RW = 10
) (
  input  logic          clk_i,
  input  logic          en_a_i,
  input  logic          en_b_i,
  input  logic [XW-1:0] x_i,
  output logic [QW-1:0] q_o,
  output logic [RW-1:0] r_o
);

  localparam int unsigned  PW    = 2 * XW;
  localparam logic [XW-1:0] Recip = XW'((64'd1 << XW) / 64'(D));

  logic [PW-1:0] prod;
  logic [XW-1:0] x_q;
  logic [QW-1:0] q0_q;
  logic [XW-1:0] rx;
  logic          fix;
  logic [QW-1:0] q_d, q_q;
  logic [RW-1:0] r_d, r_q;

  assign prod = PW'(x_i) * PW'(Recip);

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      x_q  <= x_i;
      q0_q <= prod[XW +: QW];
    end
  end

  always_comb begin
    rx  = x_q - XW'(XW'(q0_q) * XW'(D));
    fix = (rx >= XW'(D));
    q_d = fix ? q0_q + QW'(1) : q0_q;
    r_d = fix ? RW'(rx - XW'(D)) : RW'(rx);
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign q_o = q_q;
  assign r_o = r_q;

endmodule

// ===== hdl/stc_flow.sv =====
// ----------------------------------------------------------------------------
// stc_flow: pipeline valid chain
// Per-stage valid bits and load enables; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module stc_flow #(
  parameter int unsigned NS = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output logic [NS-1:0] en_o
);

  logic [NS-1:0] v_q, v_d;

  // A stage loads when it is empty or its successor loads.
  always_comb begin
    en_o[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en_o[k] = !v_q[k] || en_o[k+1];
    end
  end

  assign v_d = {v_q[NS-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en_o[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign in_ready_o  = en_o[0];
  assign out_valid_o = v_q[NS-1];

endmodule
